// ===== hdl/first_fit_partition_allocator_macros.svh =====
// Assertion macros shared by the partition allocator RTL.
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define FFPA_ASSERT_IMP(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define FFPA_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define FFPA_ASSERT_IMP(label, clk, rst, a, b, msg)
`define FFPA_ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif
`endif

// ===== hdl/ffpa_pkg.sv =====
// Types and constants of the partition allocator.
package ffpa_pkg;
   localparam int OFF_W = 20;
   localparam int LEN_W = 21;
   localparam int WANT_W = 22;
   localparam logic [LEN_W-1:0] HEAP_RESET = 21'd65536;
   localparam logic [LEN_W-1:0] HEAP_LIMIT = 21'd1048576;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_FIT     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
   localparam logic [1:0] ST_TABLE_FULL = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             used;
      logic [OFF_W-1:0] start;
      logic [LEN_W-1:0] length;
   } entry_type;
endpackage

// ===== hdl/ffpa_req_if.sv =====
// Request and response channel interfaces.
interface ffpa_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [20:0] request_bytes;
   logic [19:0] free_offset;
   modport source (output valid, opcode, request_bytes, free_offset, input ready);
   modport sink (input valid, opcode, request_bytes, free_offset, output ready);
endinterface

interface ffpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [19:0] granted_offset;
   logic [20:0] granted_bytes;
   modport source (output valid, status, granted_offset, granted_bytes, input ready);
   modport sink (input valid, status, granted_offset, granted_bytes, output ready);
endinterface

// ===== hdl/ffpa_cell.sv =====
// One partition table cell of the circulating entry chain.
module ffpa_cell
   import ffpa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      init,
   input  entry_type init_entry,
   input  logic      shift,
   input  entry_type d,
   output entry_type q
);
   entry_type entry_ff;

   // Load the initial table image, or take the neighbor's entry on a shift.
   always_ff @(posedge clock) begin
      if (reset || init) begin
         entry_ff <= init_entry;
      end else if (shift) begin
         entry_ff <= d;
      end
   end

   assign q = entry_ff;
endmodule

// ===== hdl/first_fit_partition_allocator.sv =====
// Top level of the first-fit heap partition allocator.
//
// Items arrive on req_if (opcode, request_bytes, free_offset) and each gives
// exactly one item on rsp_if (status, granted_offset, granted_bytes). Both
// channels move an item when valid and ready are high at a clock edge.
// The partition table is a ring of MAX_PARTITIONS cells. Per item, every
// entry passes the head cell once, one per cycle, where it is matched,
// marked or split; a split remainder is held in a register and slipped in.
// The request size is rounded as the item is taken (ALIGN_BYTES is a power
// of two). An item then passes the scan of the whole ring and a finish
// state, which registers the result once the rsp register is free; the
// block then returns to idle and can accept a new item. One item is in
// work at a time; the rsp register holds a finished item, and the next
// item is taken meanwhile; it waits at its end until the receiver takes
// the earlier result. Reset (synchronous, active high) and a write on
// csr_we both leave one free partition over the heap (65536 bytes after
// reset). Sizes above 1048576 saturate. The user must write configuration
// only while the block is idle; the block itself does not enforce it.
`include "first_fit_partition_allocator_macros.svh"
module first_fit_partition_allocator
   import ffpa_pkg::*;
#(
   parameter int MAX_PARTITIONS = 64,
   parameter int ALIGN_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   ffpa_req_if.sink    req_if,
   ffpa_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [20:0] csr_wdata
);
   localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
   localparam int POS_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_PARTITIONS);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_PARTITIONS - 1);
   localparam logic [WANT_W-1:0] ALIGN_W = WANT_W'(ALIGN_BYTES);
   localparam logic [WANT_W-1:0] ALIGN_MASK = WANT_W'(ALIGN_BYTES - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              op_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [WANT_W-1:0] want_ff, want_in;
   logic              done_ff, done_in;
   entry_type         pend_ff, pend_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [OFF_W-1:0]  res_off_ff, res_off_in;
   logic [LEN_W-1:0]  res_bytes_ff, res_bytes_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [OFF_W-1:0]  rsp_off_ff;
   logic [LEN_W-1:0]  rsp_bytes_ff;

   entry_type q_arr [MAX_PARTITIONS];
   entry_type d_arr [MAX_PARTITIONS];
   entry_type tail;
   entry_type head;
   entry_type init_head;
   logic [LEN_W-1:0] heap_val;
   logic init_tbl;
   logic shift;
   logic accept;
   logic out_free;

   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign init_tbl = csr_we;
   assign shift = (state_ff == S_SCAN);
   assign head = q_arr[0];

   // Initial table image: one free partition over the saturated heap size.
   always_comb begin
      heap_val = reset ? HEAP_RESET : ((csr_wdata > HEAP_LIMIT) ? HEAP_LIMIT : csr_wdata);
      init_head.valid = 1'b1;
      init_head.used = 1'b0;
      init_head.start = '0;
      init_head.length = heap_val;
   end

   // Ring of cells: each takes its right neighbor, the last takes the head result.
   for (genvar k = 0; k < MAX_PARTITIONS; k++) begin : g_cell
      if (k == MAX_PARTITIONS - 1) begin : g_last
         assign d_arr[k] = tail;
      end else begin : g_mid
         assign d_arr[k] = q_arr[k+1];
      end
      ffpa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .init       (init_tbl),
         .init_entry ((k == 0) ? init_head : entry_type'('0)),
         .shift      (shift),
         .d          (d_arr[k]),
         .q          (q_arr[k])
      );
   end

   // Request size rounded up to the alignment; a size of zero takes one unit.
   always_comb begin
      if (req_if.request_bytes == '0) begin
         want_in = ALIGN_W;
      end else begin
         want_in = (WANT_W'(req_if.request_bytes) + ALIGN_MASK) & ~ALIGN_MASK;
      end
   end

   // Head cell processing and sequencing.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      done_in = done_ff;
      pend_in = pend_ff;
      res_status_in = res_status_ff;
      res_off_in = res_off_ff;
      res_bytes_in = res_bytes_ff;
      tail = head;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in = '0;
               done_in = 1'b0;
               pend_in = '0;
               res_off_in = '0;
               res_bytes_in = '0;
               res_status_in = (req_if.opcode == OP_FREE) ? ST_NOT_FOUND : ST_NO_FIT;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (pend_ff.valid) begin
               // Slip the held remainder in; the ring's first empty entry drops out.
               tail = pend_ff;
               pend_in = head.valid ? head : entry_type'('0);
            end else if (!done_ff && head.valid) begin
               if (op_ff == OP_FREE) begin
                  if (head.start == off_ff) begin
                     tail.used = 1'b0;
                     done_in = 1'b1;
                     res_status_in = ST_OK;
                     res_off_in = head.start;
                     res_bytes_in = head.length;
                  end
               end else if (!head.used && WANT_W'(head.length) >= want_ff) begin
                  done_in = 1'b1;
                  if (WANT_W'(head.length) > want_ff && count_ff == COUNT_MAX) begin
                     res_status_in = ST_TABLE_FULL;
                  end else begin
                     res_status_in = ST_OK;
                     res_off_in = head.start;
                     res_bytes_in = LEN_W'(want_ff);
                     tail.used = 1'b1;
                     if (WANT_W'(head.length) > want_ff) begin
                        tail.length = LEN_W'(want_ff);
                        pend_in.valid = 1'b1;
                        pend_in.used = 1'b0;
                        pend_in.start = head.start + OFF_W'(want_ff);
                        pend_in.length = head.length - LEN_W'(want_ff);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
               end
            end
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff == POS_LAST) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= CNT_W'(1);
         pend_ff <= '0;
         done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= init_tbl ? CNT_W'(1) : count_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
         if (state_ff == S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      res_status_ff <= res_status_in;
      res_off_ff <= res_off_in;
      res_bytes_ff <= res_bytes_in;
      if (accept) begin
         op_ff <= req_if.opcode;
         off_ff <= req_if.free_offset;
         want_ff <= want_in;
      end
      if (state_ff == S_FINISH && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_off_ff <= res_off_ff;
         rsp_bytes_ff <= res_bytes_ff;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.granted_offset = rsp_off_ff;
   assign rsp_if.granted_bytes = rsp_bytes_ff;

   `FFPA_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= COUNT_MAX, "count overflow")
   `FFPA_ASSERT_IMP(a_pend_done, clock, reset, pend_ff.valid, done_ff && state_ff == S_SCAN, "stray remainder")
   `FFPA_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != S_IDLE, "accept not taken")
   `FFPA_ASSERT_IMP(a_finish_clean, clock, reset, state_ff == S_FINISH, !pend_ff.valid, "remainder lost")
endmodule

// ===== dv/first_fit_partition_allocator_tb.sv =====
// Self-checking testbench for the first-fit heap partition allocator.
module first_fit_partition_allocator_tb
   import ffpa_pkg::*;
();

   localparam int NUM_PARTS = 64;
   localparam int DIRECTED_ROWS = 20;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic        opcode;
      logic [20:0] request_bytes;
      logic [19:0] free_offset;
   } heap_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [19:0] granted_offset;
      logic [20:0] granted_bytes;
   } heap_rsp_type;

   // One directed row: a heap write (when set) and then one item.
   typedef struct packed {
      logic         write_heap;
      logic [20:0]  heap_value;
      heap_req_type item;
      logic         typed;
      heap_rsp_type typed_rsp;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [20:0] csr_wdata;

   ffpa_req_if req_if ();
   ffpa_rsp_if rsp_if ();

   first_fit_partition_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the partition table.
   logic [19:0] shadow_start [NUM_PARTS];
   logic [20:0] shadow_length [NUM_PARTS];
   logic        shadow_used [NUM_PARTS];
   int          shadow_count;
   logic [20:0] shadow_heap;

   heap_rsp_type pending_grants [$];
   int        error_count = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        recv_hold = 0;
   int        stall_cycles = 0;
   stim_row_type directed_rows [DIRECTED_ROWS];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Rebuild the shadow table for a new heap size, saturating as the block does.
   function automatic void shadow_reinit(input logic [20:0] value);
      shadow_heap = (value > HEAP_LIMIT) ? HEAP_LIMIT : value;
      shadow_start[0] = '0;
      shadow_length[0] = shadow_heap;
      shadow_used[0] = 1'b0;
      shadow_count = 1;
   endfunction

   // Apply one item to the shadow table and return the grant it produces.
   function automatic heap_rsp_type predict_grant(input heap_req_type item);
      heap_rsp_type grant;
      logic [21:0] want;
      int i;
      int j;
      grant = '0;
      if (item.opcode == OP_ALLOC) begin
         want = (item.request_bytes == 0) ? 22'd4 : ((22'(item.request_bytes) + 22'd3) & ~22'd3);
         for (i = 0; i < shadow_count; i++)
            if (!shadow_used[i] && 22'(shadow_length[i]) >= want) break;
         if (i >= shadow_count) begin
            grant.status = ST_NO_FIT;
            return grant;
         end
         if (22'(shadow_length[i]) > want) begin
            if (shadow_count >= NUM_PARTS) begin
               grant.status = ST_TABLE_FULL;
               return grant;
            end
            for (j = shadow_count; j > i + 1; j--) begin
               shadow_start[j] = shadow_start[j-1];
               shadow_length[j] = shadow_length[j-1];
               shadow_used[j] = shadow_used[j-1];
            end
            shadow_start[i+1] = shadow_start[i] + want[19:0];
            shadow_length[i+1] = shadow_length[i] - want[20:0];
            shadow_used[i+1] = 1'b0;
            shadow_length[i] = want[20:0];
            shadow_count++;
         end
         shadow_used[i] = 1'b1;
         grant.status = ST_OK;
         grant.granted_offset = shadow_start[i];
         grant.granted_bytes = shadow_length[i];
         return grant;
      end
      for (i = 0; i < shadow_count; i++) begin
         if (shadow_start[i] == item.free_offset) begin
            shadow_used[i] = 1'b0;
            grant.status = ST_OK;
            grant.granted_offset = shadow_start[i];
            grant.granted_bytes = shadow_length[i];
            return grant;
         end
      end
      grant.status = ST_NOT_FOUND;
      return grant;
   endfunction

   // Prediction on a scratch copy, so typed rows can be compared without side effects.
   function automatic heap_rsp_type predict_grant_peek(input heap_req_type item);
      logic [19:0]  save_start [NUM_PARTS];
      logic [20:0]  save_length [NUM_PARTS];
      logic         save_used [NUM_PARTS];
      int           save_count;
      heap_rsp_type grant;
      save_start = shadow_start;
      save_length = shadow_length;
      save_used = shadow_used;
      save_count = shadow_count;
      grant = predict_grant(item);
      shadow_start = save_start;
      shadow_length = save_length;
      shadow_used = save_used;
      shadow_count = save_count;
      return grant;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Offer one item, never back to back with the last one, idling at random
   // before it, and wait for acceptance.
   task automatic send_item(input heap_req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.opcode <= item.opcode;
      req_if.request_bytes <= item.request_bytes;
      req_if.free_offset <= item.free_offset;
      pending_grants.push_back(predict_grant(item));
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic drain_grants();
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_heap(input logic [20:0] value);
      drain_grants();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      shadow_reinit(value);
   endtask

   // Random item; frees mostly target a live partition start.
   function automatic heap_req_type random_item();
      heap_req_type item;
      item.opcode = $urandom_range(99) < 45 ? OP_FREE : OP_ALLOC;
      item.request_bytes = $urandom_range(99) < 90 ? 21'($urandom_range(shadow_heap / 6 + 8))
                                                   : 21'($urandom);
      item.free_offset = 20'($urandom);
      if ($urandom_range(99) < 85)
         item.free_offset = shadow_start[$urandom_range(shadow_count - 1)];
      return item;
   endfunction

   // Receiver: random stall, or a long hold-off counted here.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (recv_hold > 0) begin
         rsp_if.ready <= 1'b0;
         recv_hold <= recv_hold - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      heap_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected item", longint'(1), longint'(0));
         end else begin
            want = pending_grants.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch("status", longint'(rsp_if.status), longint'(want.status));
            if (rsp_if.granted_offset !== want.granted_offset)
               report_mismatch("granted_offset", longint'(rsp_if.granted_offset),
                               longint'(want.granted_offset));
            if (rsp_if.granted_bytes !== want.granted_bytes)
               report_mismatch("granted_bytes", longint'(rsp_if.granted_bytes),
                               longint'(want.granted_bytes));
         end
      end
   end

   // Watchdog on cycles with no handshake.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("first_fit_partition_allocator_tb failed");
         $finish;
      end
   end

   initial begin
      heap_rsp_type grant;
      heap_req_type item;
      int phase;
      int n;
      // Directed rows: heap write flag and value, item, typed result.
      directed_rows[0]  = '{1'b0, 21'd0, '{OP_ALLOC, 21'd0, 20'd0}, 1'b1,
                            '{ST_OK, 20'd0, 21'd4}};
      directed_rows[1]  = '{1'b0, 21'd0, '{OP_ALLOC, 21'd5, 20'd0}, 1'b1,
                            '{ST_OK, 20'd4, 21'd8}};
      directed_rows[2]  = '{1'b0, 21'd0, '{OP_FREE, 21'd0, 20'd4}, 1'b1,
                            '{ST_OK, 20'd4, 21'd8}};
      directed_rows[3]  = '{1'b0, 21'd0, '{OP_FREE, 21'd0, 20'd4}, 1'b1,
                            '{ST_OK, 20'd4, 21'd8}};
      directed_rows[4]  = '{1'b0, 21'd0, '{OP_FREE, 21'h1FFFFF, 20'hFFFFF}, 1'b1,
                            '{ST_NOT_FOUND, 20'd0, 21'd0}};
      directed_rows[5]  = '{1'b0, 21'd0, '{OP_ALLOC, 21'h1FFFFF, 20'hFFFFF}, 1'b1,
                            '{ST_NO_FIT, 20'd0, 21'd0}};
      directed_rows[6]  = '{1'b0, 21'd0, '{OP_ALLOC, 21'd8, 20'd0}, 1'b0, '0};
      directed_rows[7]  = '{1'b1, 21'h1FFFFF, '{OP_ALLOC, 21'd1048576, 20'd0}, 1'b1,
                            '{ST_OK, 20'd0, 21'd1048576}};
      directed_rows[8]  = '{1'b0, 21'd0, '{OP_ALLOC, 21'd1, 20'd0}, 1'b1,
                            '{ST_NO_FIT, 20'd0, 21'd0}};
      directed_rows[9]  = '{1'b0, 21'd0, '{OP_FREE, 21'd0, 20'd0}, 1'b1,
                            '{ST_OK, 20'd0, 21'd1048576}};
      directed_rows[10] = '{1'b1, 21'd0, '{OP_ALLOC, 21'd0, 20'd0}, 1'b1,
                            '{ST_NO_FIT, 20'd0, 21'd0}};
      directed_rows[11] = '{1'b1, 21'd3, '{OP_ALLOC, 21'd1, 20'd0}, 1'b1,
                            '{ST_NO_FIT, 20'd0, 21'd0}};
      directed_rows[12] = '{1'b1, 21'd4, '{OP_ALLOC, 21'd3, 20'd0}, 1'b1,
                            '{ST_OK, 20'd0, 21'd4}};
      directed_rows[13] = '{1'b1, 21'd1048575, '{OP_ALLOC, 21'd1048575, 20'd0}, 1'b1,
                            '{ST_NO_FIT, 20'd0, 21'd0}};
      directed_rows[14] = '{1'b0, 21'd0, '{OP_ALLOC, 21'd1048572, 20'd0}, 1'b1,
                            '{ST_OK, 20'd0, 21'd1048572}};
      directed_rows[15] = '{1'b1, 21'd256, '{OP_ALLOC, 21'd4, 20'd0}, 1'b0, '0};
      directed_rows[16] = '{1'b0, 21'd0, '{OP_ALLOC, 21'd4, 20'd0}, 1'b0, '0};
      directed_rows[17] = '{1'b0, 21'd0, '{OP_FREE, 21'd0, 20'd2}, 1'b1,
                            '{ST_NOT_FOUND, 20'd0, 21'd0}};
      directed_rows[18] = '{1'b0, 21'd0, '{OP_FREE, 21'd0, 20'd0}, 1'b0, '0};
      directed_rows[19] = '{1'b0, 21'd0, '{OP_ALLOC, 21'd2, 20'd0}, 1'b0, '0};

      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.opcode = OP_ALLOC;
      req_if.request_bytes = '0;
      req_if.free_offset = '0;
      shadow_reinit(HEAP_RESET);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table; typed rows are checked against the predictor too.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].write_heap) write_heap(directed_rows[r].heap_value);
         if (directed_rows[r].typed) begin
            grant = predict_grant_peek(directed_rows[r].item);
            if (grant !== directed_rows[r].typed_rsp)
               report_mismatch($sformatf("directed row %0d table", r), longint'(grant),
                               longint'(directed_rows[r].typed_rsp));
         end
         send_item(directed_rows[r].item);
      end

      // Fill the table with small blocks until it reports table_full.
      write_heap(21'd65536);
      for (n = 0; n < 70; n++) send_item('{OP_ALLOC, 21'd4, 20'd0});
      send_item('{OP_ALLOC, 21'd64, 20'd0});
      send_item('{OP_FREE, 21'd0, 20'd8});
      send_item('{OP_ALLOC, 21'd4, 20'd0});

      // Random phases over several heap sizes and idle mixes.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 48 : 0;
         recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 37 : 0;
         write_heap(phase == 0 ? 21'd4096 : phase == 1 ? 21'd1048576 : 21'd300);
         if (phase == 1) recv_hold <= 600;
         for (n = 0; n < 520; n++) begin
            item = random_item();
            send_item(item);
            if (n == 260) while (pending_grants.size() != 0) @(negedge clock);
         end
      end
      write_heap(21'd65536);

      drain_grants();
      if (error_count == 0)
         $display("first_fit_partition_allocator_tb passed");
      else
         $display("first_fit_partition_allocator_tb failed");
      $finish;
   end
endmodule

// ===== first_fit_partition_allocator.f =====
+incdir+hdl
hdl/ffpa_pkg.sv
hdl/ffpa_req_if.sv
hdl/ffpa_cell.sv
hdl/first_fit_partition_allocator.sv
dv/first_fit_partition_allocator_tb.sv
